// ===== rtl/apg_pkg.sv =====
// ----------------------------------------------------------------------------
// apg_pkg
// shared types and constants of the alarm pattern generator
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int TimeW  = 32;
  localparam int EventW = 32;
  localparam int LevelW = 3;
  localparam int InW    = 72;
  localparam int OutW   = 8;

  // all pattern periods divide this one
  localparam int BaseMod   = 15000;
  localparam int HalfW     = TimeW / 2;
  localparam int HiWeight  = (1 << HalfW) % BaseMod;
  localparam int FoldW     = 29;
  localparam int QuoW      = 15;
  localparam int RemW      = 14;
  localparam int RecipShift = 42;
  localparam int BaseRecip = 293203101;

  // r / 125 by reciprocal
  localparam int D125W      = 7;
  localparam int D125Recip  = 16778;
  localparam int D125Shift  = 21;
  localparam int D125ProdW  = 28;

  // d / 3 by reciprocal on six-bit values
  localparam int D250W     = 6;
  localparam int Div3Recip = 43;
  localparam int Div3Shift = 7;
  localparam int Div3ProdW = 12;

  localparam int NoticeBeepMs = 100;
  localparam int WarnPeriodMs = 3000;
  localparam int WarnBeepMs   = 150;
  localparam int WarnGapMs    = 150;
  localparam int FaultPeriodMs = 5000;
  localparam int FaultBeepMs  = 100;
  localparam int FaultGapMs   = 100;
  localparam int CritGapSlot  = 2;

  typedef enum logic [LevelW-1:0] {
    LVL_OTHER    = 3'd0,
    LVL_NOTICE   = 3'd1,
    LVL_WARNING  = 3'd2,
    LVL_CRITICAL = 3'd3,
    LVL_FAULT    = 3'd4
  } level_e;

  typedef struct packed {
    logic   off;
    logic   mute;
    logic   notice_beep;
    level_e level;
  } ctl_t;

endpackage

// ===== rtl/apg_state.sv =====
// ----------------------------------------------------------------------------
// apg_state
// takes requests, tracks level, event and acknowledge, computes elapsed time
// ----------------------------------------------------------------------------
module apg_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        state_present_i,
  input  logic                        run_en_i,
  input  logic [apg_pkg::LevelW-1:0]  alarm_level_i,
  input  logic [apg_pkg::EventW-1:0]  event_number_i,
  input  logic                        acked_i,
  input  logic                        buzz_en_i,
  input  logic [apg_pkg::TimeW-1:0]   now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [apg_pkg::TimeW-1:0]   elapsed_o,
  output apg_pkg::ctl_t               ctl_o
);

  apg_pkg::level_e             last_level_q, last_level_d;
  logic [apg_pkg::TimeW-1:0]   start_q, start_d;
  logic [apg_pkg::EventW-1:0]  last_event_q, last_event_d;
  logic                        last_acked_q, last_acked_d;
  logic                        valid_q;
  logic [apg_pkg::TimeW-1:0]   elapsed_q, elapsed_d;
  apg_pkg::ctl_t               ctl_q, ctl_d;
  logic                        accept;
  logic                        off;
  logic                        restart;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign off = !state_present_i || !run_en_i ||
               (alarm_level_i < apg_pkg::LevelW'(apg_pkg::LVL_NOTICE)) ||
               (alarm_level_i > apg_pkg::LevelW'(apg_pkg::LVL_FAULT));

  assign restart = (last_level_q != apg_pkg::level_e'(alarm_level_i)) ||
                   (last_event_q != event_number_i) ||
                   (last_acked_q && !acked_i);

  always_comb begin
    last_level_d = last_level_q;
    start_d      = start_q;
    last_event_d = last_event_q;
    last_acked_d = last_acked_q;
    if (accept) begin
      if (off) begin
        last_level_d = apg_pkg::LVL_OTHER;
        start_d      = '0;
        last_event_d = '0;
        last_acked_d = 1'b0;
      end else begin
        last_level_d = apg_pkg::level_e'(alarm_level_i);
        last_event_d = event_number_i;
        last_acked_d = acked_i;
        if (restart) begin
          start_d = now_ms_i;
        end
      end
    end
  end

  always_comb begin
    elapsed_d         = restart ? '0 : (now_ms_i - start_q);
    ctl_d.off         = off;
    ctl_d.mute        = !buzz_en_i || acked_i;
    ctl_d.notice_beep = elapsed_d < apg_pkg::TimeW'(apg_pkg::NoticeBeepMs);
    ctl_d.level       = apg_pkg::level_e'(alarm_level_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= apg_pkg::LVL_OTHER;
      start_q      <= '0;
      last_event_q <= '0;
      last_acked_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      last_level_q <= last_level_d;
      start_q      <= start_d;
      last_event_q <= last_event_d;
      last_acked_q <= last_acked_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= elapsed_d;
      ctl_q     <= ctl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign elapsed_o   = elapsed_q;
  assign ctl_o       = ctl_q;

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && off) |=> (last_level_q == apg_pkg::LVL_OTHER) && (start_q == '0) &&
                        (last_event_q == '0) && !last_acked_q)
    else $error("state not cleared after forced-off request");

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !off && restart) |=> (elapsed_q == '0) && ctl_q.notice_beep)
    else $error("restart did not zero elapsed time");

  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("accepted request lost in state stage");

endmodule

// ===== rtl/apg_reduce.sv =====
// ----------------------------------------------------------------------------
// apg_reduce
// reduces elapsed time modulo the common pattern period in three stages
// ----------------------------------------------------------------------------
module apg_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [apg_pkg::TimeW-1:0]  elapsed_i,
  input  apg_pkg::ctl_t              ctl_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [apg_pkg::RemW-1:0]   rem_o,
  output apg_pkg::ctl_t              ctl_o
);

  localparam int ProdW = 2 * apg_pkg::FoldW;

  logic                          v2_q, v3_q, v4_q;
  logic                          rdy2, rdy3, rdy4;
  logic [apg_pkg::FoldW-1:0]     fold_d, fold2_q, fold3_q;
  logic [ProdW-1:0]              prod;
  logic [apg_pkg::QuoW-1:0]      quo_d, quo3_q;
  logic [apg_pkg::FoldW-1:0]     rem_full;
  logic [apg_pkg::RemW-1:0]      rem4_q;
  apg_pkg::ctl_t                 ctl2_q, ctl3_q, ctl4_q;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  // fold the upper half back using 2^16 mod period
  assign fold_d = apg_pkg::FoldW'(elapsed_i[apg_pkg::TimeW-1:apg_pkg::HalfW]) *
                  apg_pkg::FoldW'(apg_pkg::HiWeight) +
                  apg_pkg::FoldW'(elapsed_i[apg_pkg::HalfW-1:0]);

  assign prod  = ProdW'(fold2_q) * ProdW'(apg_pkg::BaseRecip);
  assign quo_d = prod[apg_pkg::RecipShift +: apg_pkg::QuoW];

  assign rem_full = fold3_q -
                    apg_pkg::FoldW'(quo3_q) * apg_pkg::FoldW'(apg_pkg::BaseMod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      fold2_q <= fold_d;
      ctl2_q  <= ctl_i;
    end
    if (rdy3) begin
      fold3_q <= fold2_q;
      quo3_q  <= quo_d;
      ctl3_q  <= ctl2_q;
    end
    if (rdy4) begin
      rem4_q <= rem_full[apg_pkg::RemW-1:0];
      ctl4_q <= ctl3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign rem_o       = rem4_q;
  assign ctl_o       = ctl4_q;

endmodule

// ===== rtl/apg_decode.sv =====
// ----------------------------------------------------------------------------
// apg_decode
// decodes the reduced time into buzzer and led patterns, holds the result
// ----------------------------------------------------------------------------
module apg_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [apg_pkg::RemW-1:0]  rem_i,
  input  apg_pkg::ctl_t             ctl_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      buzz_o,
  output logic                      led0_on_o,
  output logic                      led1_on_o
);

  logic                           v5_q, v6_q;
  logic                           rdy5, rdy6;
  logic [apg_pkg::D125ProdW-1:0]  d125_prod;
  logic [apg_pkg::D125W-1:0]      d125_d, d125_q;
  logic [apg_pkg::RemW-1:0]       warn_p, fault_p;
  logic                           warn_buz_d, warn_buz_q;
  logic                           fault_buz_d, fault_buz_q;
  apg_pkg::ctl_t                  ctl5_q;
  logic [apg_pkg::D250W-1:0]      d250;
  logic [apg_pkg::Div3ProdW-1:0]  div3_prod;
  logic [apg_pkg::D250W-1:0]      div3_q3;
  logic [1:0]                     mod3;
  logic                           buz, led0, led1;
  logic                           buz_q, led0_q, led1_q;

  assign rdy6       = !v6_q || out_ready_i;
  assign rdy5       = !v5_q || rdy6;
  assign in_ready_o = rdy5;

  assign d125_prod = apg_pkg::D125ProdW'(rem_i) * apg_pkg::D125ProdW'(apg_pkg::D125Recip);
  assign d125_d    = d125_prod[apg_pkg::D125Shift +: apg_pkg::D125W];

  always_comb begin
    priority if (rem_i >= apg_pkg::RemW'(4 * apg_pkg::WarnPeriodMs)) begin
      warn_p = rem_i - apg_pkg::RemW'(4 * apg_pkg::WarnPeriodMs);
    end else if (rem_i >= apg_pkg::RemW'(3 * apg_pkg::WarnPeriodMs)) begin
      warn_p = rem_i - apg_pkg::RemW'(3 * apg_pkg::WarnPeriodMs);
    end else if (rem_i >= apg_pkg::RemW'(2 * apg_pkg::WarnPeriodMs)) begin
      warn_p = rem_i - apg_pkg::RemW'(2 * apg_pkg::WarnPeriodMs);
    end else if (rem_i >= apg_pkg::RemW'(apg_pkg::WarnPeriodMs)) begin
      warn_p = rem_i - apg_pkg::RemW'(apg_pkg::WarnPeriodMs);
    end else begin
      warn_p = rem_i;
    end
  end

  always_comb begin
    priority if (rem_i >= apg_pkg::RemW'(2 * apg_pkg::FaultPeriodMs)) begin
      fault_p = rem_i - apg_pkg::RemW'(2 * apg_pkg::FaultPeriodMs);
    end else if (rem_i >= apg_pkg::RemW'(apg_pkg::FaultPeriodMs)) begin
      fault_p = rem_i - apg_pkg::RemW'(apg_pkg::FaultPeriodMs);
    end else begin
      fault_p = rem_i;
    end
  end

  assign warn_buz_d =
    (warn_p < apg_pkg::RemW'(apg_pkg::WarnBeepMs)) ||
    ((warn_p >= apg_pkg::RemW'(apg_pkg::WarnBeepMs + apg_pkg::WarnGapMs)) &&
     (warn_p < apg_pkg::RemW'(2 * apg_pkg::WarnBeepMs + apg_pkg::WarnGapMs)));

  assign fault_buz_d =
    (fault_p < apg_pkg::RemW'(apg_pkg::FaultBeepMs)) ||
    ((fault_p >= apg_pkg::RemW'(apg_pkg::FaultBeepMs + apg_pkg::FaultGapMs)) &&
     (fault_p < apg_pkg::RemW'(2 * apg_pkg::FaultBeepMs + apg_pkg::FaultGapMs)));

  // critical beep: 250 ms slots, silent in every third slot
  assign d250      = d125_q[apg_pkg::D125W-1:1];
  assign div3_prod = apg_pkg::Div3ProdW'(d250) * apg_pkg::Div3ProdW'(apg_pkg::Div3Recip);
  assign div3_q3   = apg_pkg::D250W'(div3_prod[apg_pkg::Div3ProdW-1:apg_pkg::Div3Shift]) *
                     apg_pkg::D250W'(3);
  assign mod3      = 2'(d250 - div3_q3);

  always_comb begin
    buz  = 1'b0;
    led0 = 1'b0;
    led1 = 1'b0;
    unique case (ctl5_q.level)
      apg_pkg::LVL_NOTICE: begin
        buz = ctl5_q.notice_beep;
      end
      apg_pkg::LVL_WARNING: begin
        buz  = warn_buz_q;
        led0 = !d125_q[1];
      end
      apg_pkg::LVL_CRITICAL: begin
        buz  = (mod3 != 2'(apg_pkg::CritGapSlot));
        led0 = !d125_q[0];
        led1 = !d125_q[0];
      end
      apg_pkg::LVL_FAULT: begin
        buz  = fault_buz_q;
        led1 = !d125_q[2];
      end
      default: begin
        buz  = 1'b0;
      end
    endcase
    if (ctl5_q.mute) begin
      buz = 1'b0;
    end
    if (ctl5_q.off) begin
      buz  = 1'b0;
      led0 = 1'b0;
      led1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy5) begin
        v5_q <= in_valid_i;
      end
      if (rdy6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      d125_q      <= d125_d;
      warn_buz_q  <= warn_buz_d;
      fault_buz_q <= fault_buz_d;
      ctl5_q      <= ctl_i;
    end
    if (rdy6) begin
      buz_q  <= buz;
      led0_q <= led0;
      led1_q <= led1;
    end
  end

  assign out_valid_o = v6_q;
  assign buzz_o      = buz_q;
  assign led0_on_o   = led0_q;
  assign led1_on_o   = led1_q;

endmodule

// ===== rtl/alarm_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// alarm_pattern_generator_core
// buzzer and led pattern generator for alarm level updates
// ----------------------------------------------------------------------------
// each request on the slave stream is one alarm update; each update gives
// exactly one result on the master stream (buzzer, led0, led1 drive levels)
// via the state, fold, quotient, remainder, decode and result registers; one
// request per cycle is taken while the receiver keeps up, set by the state
// compare stage that stores the level, event and acknowledge of each request
// the elapsed time is reduced through a fold, a reciprocal multiply and a
// remainder stage, then decoded into patterns and held in the result register
// reset clears the stored level, event, acknowledge and start time and
// empties the pipeline; no result is pending after reset
// when the receiver stalls the pipeline keeps filling its empty stages and
// stops taking requests only once every stage holds a result
// ----------------------------------------------------------------------------
module alarm_pattern_generator_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // state_present, run_en, alarm_level[2:0], event_number[31:0],
  // acked, buzz_en, now_ms[31:0], zero pad
  input  logic [apg_pkg::InW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // buzz, led0_on, led1_on, zero pad
  output logic [apg_pkg::OutW-1:0] m_axis_tdata_o
);

  logic                        st_valid, st_ready;
  logic [apg_pkg::TimeW-1:0]   st_elapsed;
  apg_pkg::ctl_t               st_ctl;
  logic                        rd_valid, rd_ready;
  logic [apg_pkg::RemW-1:0]    rd_rem;
  apg_pkg::ctl_t               rd_ctl;
  logic                        buzz, led0_on, led1_on;

  apg_state u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .state_present_i (s_axis_tdata_i[0]),
    .run_en_i        (s_axis_tdata_i[1]),
    .alarm_level_i   (s_axis_tdata_i[4:2]),
    .event_number_i  (s_axis_tdata_i[36:5]),
    .acked_i         (s_axis_tdata_i[37]),
    .buzz_en_i       (s_axis_tdata_i[38]),
    .now_ms_i        (s_axis_tdata_i[70:39]),
    .out_valid_o     (st_valid),
    .out_ready_i     (st_ready),
    .elapsed_o       (st_elapsed),
    .ctl_o           (st_ctl)
  );

  apg_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid),
    .in_ready_o  (st_ready),
    .elapsed_i   (st_elapsed),
    .ctl_i       (st_ctl),
    .out_valid_o (rd_valid),
    .out_ready_i (rd_ready),
    .rem_o       (rd_rem),
    .ctl_o       (rd_ctl)
  );

  apg_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_valid),
    .in_ready_o  (rd_ready),
    .rem_i       (rd_rem),
    .ctl_i       (rd_ctl),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .buzz_o      (buzz),
    .led0_on_o   (led0_on),
    .led1_on_o   (led1_on)
  );

  assign m_axis_tdata_o = {5'b0, led1_on, led0_on, buzz};

endmodule

// ===== bench/alarm_pattern_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_pattern_generator_core_tb
// self-checking bench for the alarm pattern generator core
// ----------------------------------------------------------------------------
// alarm updates go in on the slave stream from a queue; a local predictor
// keeps its own copy of the held level, event, acknowledge and start time
// and works out the buzzer and led drive for every accepted request; the
// monitor checks each result against the oldest prediction, field by field
// a directed set covers the forced-off cases, pattern edges, restarts,
// muting and the wrap of the elapsed time; random runs of alarm sequences with
// some noise follow, under several sender and receiver idling mixes
// ----------------------------------------------------------------------------
module alarm_pattern_generator_core_tb;

  localparam int unsigned NoticeMs     = 100;
  localparam int unsigned WarnPeriod   = 3000;
  localparam int unsigned WarnBeep     = 150;
  localparam int unsigned WarnGap      = 150;
  localparam int unsigned WarnLedPer   = 500;
  localparam int unsigned WarnLedOn    = 250;
  localparam int unsigned CritPeriod   = 750;
  localparam int unsigned CritBeep     = 500;
  localparam int unsigned CritLedPer   = 250;
  localparam int unsigned CritLedOn    = 125;
  localparam int unsigned FaultPeriod  = 5000;
  localparam int unsigned FaultBeep    = 100;
  localparam int unsigned FaultGap     = 100;
  localparam int unsigned FaultLedPer  = 1000;
  localparam int unsigned FaultLedOn   = 500;
  localparam int          CycleLimit   = 400000;
  localparam int          DrainCycles  = 24;

  // lowest bit first: state_present, run_en, alarm_level, event_number,
  // acked, buzz_en, now_ms, pad
  typedef struct packed {
    logic                         pad;
    logic [apg_pkg::TimeW-1:0]    now_ms;
    logic                         buzz_en;
    logic                         acked;
    logic [apg_pkg::EventW-1:0]   event_number;
    logic [apg_pkg::LevelW-1:0]   alarm_level;
    logic                         run_en;
    logic                         state_present;
  } update_t;

  typedef struct packed {
    logic [4:0] pad;
    logic       led1;
    logic       led0;
    logic       buzzer;
  } drive_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [apg_pkg::InW-1:0]  s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [apg_pkg::OutW-1:0] m_tdata;

  update_t update_q[$];
  drive_t  drive_q[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  apg_pkg::level_e             held_level = apg_pkg::LVL_OTHER;
  logic [apg_pkg::TimeW-1:0]   held_start = '0;
  logic [apg_pkg::EventW-1:0]  held_event = '0;
  logic                        held_acked = 1'b0;

  alarm_pattern_generator_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic two_beeps(input logic [apg_pkg::TimeW-1:0] p,
                                     input int unsigned beep, input int unsigned gap);
    return (p < beep) || (p >= beep + gap && p < beep + gap + beep);
  endfunction

  function automatic drive_t next_drive(input update_t u);
    drive_t                    d;
    apg_pkg::level_e           lvl;
    logic [apg_pkg::TimeW-1:0] e;
    d = '0;
    lvl = apg_pkg::level_e'(u.alarm_level);
    if (!u.state_present || !u.run_en || lvl < apg_pkg::LVL_NOTICE ||
        lvl > apg_pkg::LVL_FAULT) begin
      held_level = apg_pkg::LVL_OTHER;
      held_start = '0;
      held_event = '0;
      held_acked = 1'b0;
      return d;
    end
    if (held_level != lvl || held_event != u.event_number || (held_acked && !u.acked))
      held_start = u.now_ms;
    held_level = lvl;
    held_event = u.event_number;
    held_acked = u.acked;
    e = u.now_ms - held_start;
    case (lvl)
      apg_pkg::LVL_NOTICE: begin
        d.buzzer = e < NoticeMs;
      end
      apg_pkg::LVL_WARNING: begin
        d.buzzer = two_beeps(e % WarnPeriod, WarnBeep, WarnGap);
        d.led0 = (e % WarnLedPer) < WarnLedOn;
      end
      apg_pkg::LVL_CRITICAL: begin
        d.buzzer = (e % CritPeriod) < CritBeep;
        d.led0 = (e % CritLedPer) < CritLedOn;
        d.led1 = d.led0;
      end
      default: begin
        d.buzzer = two_beeps(e % FaultPeriod, FaultBeep, FaultGap);
        d.led1 = (e % FaultLedPer) < FaultLedOn;
      end
    endcase
    if (!u.buzz_en || u.acked)
      d.buzzer = 1'b0;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("mismatch at %0t: %s got %0b want %0b", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic push_update(input logic present, input logic run, input logic [2:0] lvl,
                             input logic [31:0] ev, input logic ack, input logic ben,
                             input logic [31:0] now);
    update_t u;
    u = '0;
    u.state_present = present;
    u.run_en = run;
    u.alarm_level = lvl;
    u.event_number = ev;
    u.acked = ack;
    u.buzz_en = ben;
    u.now_ms = now;
    update_q.push_back(u);
  endtask

  // runs of updates on one alarm with a moving clock, plus some noise
  task automatic push_alarm_runs(input int count);
    int          n;
    int          len;
    logic [2:0]  lvl;
    logic [31:0] ev;
    logic [31:0] now;
    logic        ack;
    logic        ben;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        push_update(1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom_range(7)),
                    $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
        n++;
      end else begin
        lvl = 3'($urandom_range(apg_pkg::LVL_NOTICE, apg_pkg::LVL_FAULT));
        ev = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom;
        now = $urandom;
        ack = 1'b0;
        ben = $urandom_range(7) != 0;
        len = $urandom_range(4, 16);
        for (int i = 0; i < len && n < count; i++) begin
          if ($urandom_range(29) == 0)
            push_update(1'($urandom_range(1)), 1'b0, lvl, ev, ack, ben, now);
          else
            push_update(1'b1, 1'b1, lvl, ev, ack, ben, now);
          n++;
          case ($urandom_range(19))
            0:       now = now + $urandom;
            1, 2:    now = now + $urandom_range(6000);
            default: now = now + $urandom_range(200);
          endcase
          if ($urandom_range(9) == 0) ack = !ack;
          if ($urandom_range(9) == 0) ben = !ben;
          if ($urandom_range(19) == 0) ev = $urandom;
          if ($urandom_range(24) == 0)
            lvl = 3'($urandom_range(apg_pkg::LVL_NOTICE, apg_pkg::LVL_FAULT));
        end
      end
    end
  endtask

  // driver: the front of the queue stays on the bus until it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        drive_q.push_back(next_drive(update_q[0]));
        update_q.pop_front();
      end
      if (!s_tvalid || s_tready) begin
        if (update_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= update_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (drive_q.size() == 0) begin
          $display("mismatch at %0t: result with no request pending", $time);
          mismatch_cnt++;
        end else begin
          want = drive_q.pop_front();
          if (got.buzzer !== want.buzzer) report_mismatch("buzz", got.buzzer, want.buzzer);
          if (got.led0 !== want.led0) report_mismatch("led0_on", got.led0, want.led0);
          if (got.led1 !== want.led1) report_mismatch("led1_on", got.led1, want.led1);
        end
      end
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("alarm_pattern_generator_core regression: fail");
    $finish;
  end

  initial begin
    int send_mix[4];
    int recv_mix[4];
    send_mix = '{0, 87, 0, 36};
    recv_mix = '{0, 0, 87, 36};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // forced off
    push_update(1'b0, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b1, 32'd0);
    push_update(1'b1, 1'b0, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b1, 32'd0);
    push_update(1'b1, 1'b1, apg_pkg::LVL_OTHER, 32'd1, 1'b0, 1'b1, 32'd0);
    push_update(1'b1, 1'b1, 3'd5, 32'd1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_update(1'b1, 1'b1, 3'd6, 32'd1, 1'b0, 1'b0, 32'd0);
    push_update(1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // notice beep edge and the recurrence after the elapsed time wraps
    push_update(1'b1, 1'b1, apg_pkg::LVL_NOTICE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    push_update(1'b1, 1'b1, apg_pkg::LVL_NOTICE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd98);
    push_update(1'b1, 1'b1, apg_pkg::LVL_NOTICE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd99);
    push_update(1'b1, 1'b1, apg_pkg::LVL_NOTICE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFE);
    push_update(1'b1, 1'b1, apg_pkg::LVL_NOTICE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    // warning, acknowledge mute and withdrawal, buzzer disable
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b1, 32'd1000);
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b1, 32'd1300);
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b1, 1'b1, 32'd1449);
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b1, 32'd1460);
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd1, 1'b0, 1'b0, 32'd1470);
    // critical
    push_update(1'b1, 1'b1, apg_pkg::LVL_CRITICAL, 32'd1, 1'b0, 1'b1, 32'd5000);
    push_update(1'b1, 1'b1, apg_pkg::LVL_CRITICAL, 32'd1, 1'b0, 1'b1, 32'd5499);
    push_update(1'b1, 1'b1, apg_pkg::LVL_CRITICAL, 32'd1, 1'b0, 1'b1, 32'd5500);
    // fault, event change restart
    push_update(1'b1, 1'b1, apg_pkg::LVL_FAULT, 32'd2, 1'b0, 1'b1, 32'd0);
    push_update(1'b1, 1'b1, apg_pkg::LVL_FAULT, 32'd2, 1'b0, 1'b1, 32'd250);
    push_update(1'b1, 1'b1, apg_pkg::LVL_FAULT, 32'd2, 1'b0, 1'b1, 32'd500);
    push_update(1'b1, 1'b1, apg_pkg::LVL_FAULT, 32'd3, 1'b0, 1'b1, 32'd600);
    push_update(1'b0, 1'b0, apg_pkg::LVL_FAULT, 32'd3, 1'b0, 1'b1, 32'd700);
    push_update(1'b1, 1'b1, apg_pkg::LVL_WARNING, 32'd0, 1'b0, 1'b1, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      push_alarm_runs(190);
      while (update_q.size() != 0 || drive_q.size() != 0)
        @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (drive_q.size() != 0) begin
      $display("mismatch: %0d results never arrived", drive_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0)
      $display("alarm_pattern_generator_core regression: pass");
    else
      $display("alarm_pattern_generator_core regression: fail");
    $finish;
  end

endmodule

// ===== alarm_pattern_generator_core.f =====
rtl/apg_pkg.sv
rtl/apg_state.sv
rtl/apg_reduce.sv
rtl/apg_decode.sv
rtl/alarm_pattern_generator_core.sv
bench/alarm_pattern_generator_core_tb.sv
